// File: src/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// Shared types and constants of the OpenPGP packet deframer: request payloads,
// parser state, phase codes, byte roles, error codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package opd_pkg;

    localparam int LEN_BITS = 32;
    localparam int ACC_BITS = 32;
    localparam int MASK_BITS = 64;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [63:0] LEN_MAX_WIDE = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [ACC_BITS-1:0] LEN_MAX = LEN_MAX_WIDE[ACC_BITS-1:0];

    localparam logic [7:0] OCT_TWO_LO = 8'd192;
    localparam logic [7:0] OCT_TWO_HI = 8'd223;
    localparam logic [7:0] OCT_FIVE = 8'd255;
    localparam logic [ACC_BITS-1:0] TWO_OCT_BIAS = ACC_BITS'(192);

    localparam logic [CFG_IDX_BITS-1:0] CFG_VALID_TAG = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PARTIAL_OK = 1'd1;

    localparam logic [MASK_BITS-1:0] VALID_TAG_RESET = 64'd4095998;
    localparam logic [MASK_BITS-1:0] PARTIAL_OK_RESET = 64'd1313536;

    localparam logic [1:0] ROLE_TAG = 2'd0;
    localparam logic [1:0] ROLE_LEN = 2'd1;
    localparam logic [1:0] ROLE_BODY = 2'd2;
    localparam logic [1:0] ROLE_SKIP = 2'd3;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_BIT7 = 3'd1;
    localparam logic [2:0] ERR_BAD_TAG = 3'd2;
    localparam logic [2:0] ERR_TRUNC = 3'd3;
    localparam logic [2:0] ERR_PARTIAL = 3'd4;

    localparam logic [1:0] LLT_ONE = 2'd0;
    localparam logic [1:0] LLT_TWO = 2'd1;
    localparam logic [1:0] LLT_INDET = 2'd3;

    typedef enum logic [4:0] {
        PH_TAG   = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_BODY  = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_INDET = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in;

    typedef struct packed {
        logic [1:0] byte_role;
        logic [5:0] packet_tag;
        logic       new_format;
        logic [7:0] body_data;
        logic       packet_end;
        logic [2:0] error_code;
    } t_out;

    typedef struct packed {
        t_phase              phase;
        logic [5:0]          current_tag;
        logic                is_new_format;
        logic [1:0]          legacy_length_type;
        logic [7:0]          first_length_octet;
        logic [ACC_BITS-1:0] length_accumulator;
        logic [2:0]          length_octets_left;
        logic [LEN_BITS-1:0] body_remaining;
        logic                chunk_is_partial;
    } t_state;

endpackage

`default_nettype wire

// File: src/opd_step.sv
// ----------------------------------------------------------------------------
// opd_step
// Next-state and result logic for one octet: tag decode, length header
// decode, body counting, indeterminate-length bodies, skip after a bad tag.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_step (
    input  wire opd_pkg::t_state                  i_state,
    input  wire opd_pkg::t_in                     i_in,
    input  wire logic [opd_pkg::MASK_BITS-1:0]    i_valid_tag_mask,
    input  wire logic [opd_pkg::MASK_BITS-1:0]    i_partial_ok_mask,
    output opd_pkg::t_state                       o_state,
    output opd_pkg::t_out                         o_out
);

    opd_pkg::t_state                n_st;
    opd_pkg::t_out                  res;
    logic [7:0]                     b;
    logic                           eod;
    logic                           fin;
    logic [opd_pkg::ACC_BITS-1:0]   fin_len;
    logic [opd_pkg::ACC_BITS-1:0]   fin_sat;
    logic [7:0]                     two_lo;
    logic [opd_pkg::ACC_BITS-1:0]   acc_shift;
    logic [2:0]                     left_dec;

    assign b = i_in.data_byte;
    assign eod = i_in.end_of_data;
    assign two_lo = b - opd_pkg::OCT_TWO_LO;
    assign acc_shift = {i_state.length_accumulator[opd_pkg::ACC_BITS-9:0], b};
    assign left_dec = i_state.length_octets_left - 3'd1;

    always_comb begin
        n_st = i_state;
        res = '0;
        fin = 1'b0;
        fin_len = '0;
        case (i_state.phase)
            opd_pkg::PH_LEN: begin
                res.byte_role = opd_pkg::ROLE_LEN;
                if (i_state.is_new_format && (i_state.length_octets_left == 3'd0)) begin
                    if (b < opd_pkg::OCT_TWO_LO) begin
                        n_st.chunk_is_partial = 1'b0;
                        fin = 1'b1;
                        fin_len = {{(opd_pkg::ACC_BITS-8){1'b0}}, b};
                    end else if (b <= opd_pkg::OCT_TWO_HI) begin
                        n_st.first_length_octet = b;
                        n_st.length_accumulator = {{(opd_pkg::ACC_BITS-8){1'b0}}, two_lo};
                        n_st.length_octets_left = 3'd1;
                    end else if (b == opd_pkg::OCT_FIVE) begin
                        n_st.first_length_octet = b;
                        n_st.length_accumulator = '0;
                        n_st.length_octets_left = 3'd4;
                    end else begin
                        n_st.chunk_is_partial = 1'b1;
                        if (!i_partial_ok_mask[i_state.current_tag]) begin
                            res.error_code = opd_pkg::ERR_PARTIAL;
                        end
                        fin = 1'b1;
                        fin_len = opd_pkg::ACC_BITS'(1) << b[4:0];
                    end
                    if (!fin && eod) begin
                        res.error_code = opd_pkg::ERR_TRUNC;
                        n_st.phase = opd_pkg::PH_TAG;
                        n_st.chunk_is_partial = 1'b0;
                    end
                end else begin
                    n_st.length_accumulator = acc_shift;
                    n_st.length_octets_left = left_dec;
                    if (left_dec == 3'd0) begin
                        fin = 1'b1;
                        fin_len = acc_shift;
                        if (i_state.is_new_format) begin
                            n_st.chunk_is_partial = 1'b0;
                            if ((i_state.first_length_octet >= opd_pkg::OCT_TWO_LO) &&
                                (i_state.first_length_octet <= opd_pkg::OCT_TWO_HI)) begin
                                fin_len = acc_shift + opd_pkg::TWO_OCT_BIAS;
                            end
                        end
                    end else if (eod) begin
                        res.error_code = opd_pkg::ERR_TRUNC;
                        n_st.phase = opd_pkg::PH_TAG;
                        n_st.chunk_is_partial = 1'b0;
                    end
                end
            end
            opd_pkg::PH_BODY: begin
                res.byte_role = opd_pkg::ROLE_BODY;
                res.body_data = b;
                n_st.body_remaining = i_state.body_remaining - opd_pkg::LEN_BITS'(1);
                if ((n_st.body_remaining == '0) && !i_state.chunk_is_partial) begin
                    res.packet_end = 1'b1;
                    n_st.phase = opd_pkg::PH_TAG;
                end else if (eod) begin
                    res.error_code = opd_pkg::ERR_TRUNC;
                    n_st.phase = opd_pkg::PH_TAG;
                    n_st.chunk_is_partial = 1'b0;
                end else if (n_st.body_remaining == '0) begin
                    n_st.length_octets_left = 3'd0;
                    n_st.length_accumulator = '0;
                    n_st.phase = opd_pkg::PH_LEN;
                end
            end
            opd_pkg::PH_SKIP: begin
                res.byte_role = opd_pkg::ROLE_SKIP;
                if (eod) begin
                    n_st.phase = opd_pkg::PH_TAG;
                end
            end
            opd_pkg::PH_INDET: begin
                res.byte_role = opd_pkg::ROLE_BODY;
                res.body_data = b;
                if (eod) begin
                    res.packet_end = 1'b1;
                    n_st.phase = opd_pkg::PH_TAG;
                end
            end
            default: begin
                res.byte_role = opd_pkg::ROLE_TAG;
                n_st.chunk_is_partial = 1'b0;
                if (b[6]) begin
                    n_st.is_new_format = 1'b1;
                    n_st.current_tag = b[5:0];
                    n_st.legacy_length_type = opd_pkg::LLT_ONE;
                end else begin
                    n_st.is_new_format = 1'b0;
                    n_st.current_tag = {2'b00, b[5:2]};
                    n_st.legacy_length_type = b[1:0];
                end
                if (!b[7]) begin
                    res.error_code = opd_pkg::ERR_BIT7;
                end
                n_st.length_accumulator = '0;
                n_st.first_length_octet = 8'd0;
                if (!i_valid_tag_mask[n_st.current_tag]) begin
                    res.error_code = opd_pkg::ERR_BAD_TAG;
                    n_st.phase = eod ? opd_pkg::PH_TAG : opd_pkg::PH_SKIP;
                end else if (!n_st.is_new_format &&
                             (n_st.legacy_length_type == opd_pkg::LLT_INDET)) begin
                    if (eod) begin
                        res.packet_end = 1'b1;
                        n_st.phase = opd_pkg::PH_TAG;
                    end else begin
                        n_st.phase = opd_pkg::PH_INDET;
                    end
                end else if (eod) begin
                    res.error_code = opd_pkg::ERR_TRUNC;
                    n_st.phase = opd_pkg::PH_TAG;
                end else begin
                    if (n_st.is_new_format) begin
                        n_st.length_octets_left = 3'd0;
                    end else if (n_st.legacy_length_type == opd_pkg::LLT_ONE) begin
                        n_st.length_octets_left = 3'd1;
                    end else if (n_st.legacy_length_type == opd_pkg::LLT_TWO) begin
                        n_st.length_octets_left = 3'd2;
                    end else begin
                        n_st.length_octets_left = 3'd4;
                    end
                    n_st.phase = opd_pkg::PH_LEN;
                end
            end
        endcase
        fin_sat = (fin_len > opd_pkg::LEN_MAX) ? opd_pkg::LEN_MAX : fin_len;
        if (fin) begin
            if (fin_sat == '0) begin
                res.packet_end = 1'b1;
                n_st.phase = opd_pkg::PH_TAG;
                n_st.chunk_is_partial = 1'b0;
            end else if (eod) begin
                res.error_code = opd_pkg::ERR_TRUNC;
                n_st.phase = opd_pkg::PH_TAG;
                n_st.chunk_is_partial = 1'b0;
            end else begin
                n_st.body_remaining = fin_sat[opd_pkg::LEN_BITS-1:0];
                n_st.phase = opd_pkg::PH_BODY;
            end
        end
        res.packet_tag = n_st.current_tag;
        res.new_format = n_st.is_new_format;
    end

    assign o_state = n_st;
    assign o_out = res;

endmodule

`default_nettype wire

// File: src/opd_obuf.sv
// ----------------------------------------------------------------------------
// opd_obuf
// Result register with a skid stage: holds up to two result requests so the
// parser keeps taking octets while a result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_obuf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire opd_pkg::t_out i_data,
    output logic               o_space,
    output logic               o_valid,
    input  wire logic          i_ready,
    output opd_pkg::t_out      o_data
);

    logic          r_valid;
    logic          n_valid;
    opd_pkg::t_out r_data;
    opd_pkg::t_out n_data;
    logic          r_sk_valid;
    logic          n_sk_valid;
    opd_pkg::t_out r_sk_data;
    opd_pkg::t_out n_sk_data;
    logic          push;
    logic          pop;

    assign push = i_push && !r_sk_valid;
    assign pop = r_valid && i_ready;

    always_comb begin
        n_valid = r_valid;
        n_data = r_data;
        n_sk_valid = r_sk_valid;
        n_sk_data = r_sk_data;
        if (!r_valid || pop) begin
            if (r_sk_valid) begin
                n_valid = 1'b1;
                n_data = r_sk_data;
                n_sk_valid = 1'b0;
            end else begin
                n_valid = push;
                if (push) begin
                    n_data = i_data;
                end
            end
        end else if (push) begin
            n_sk_valid = 1'b1;
            n_sk_data = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sk_valid <= n_sk_valid;
        end
        r_data <= n_data;
        r_sk_data <= n_sk_data;
    end

    assign o_space = !r_sk_valid;
    assign o_valid = r_valid;
    assign o_data = r_data;

endmodule

`default_nettype wire

// File: src/openpgp_packet_deframer.sv
// ----------------------------------------------------------------------------
// openpgp_packet_deframer
// Byte-serial OpenPGP packet header parser: one result per input octet.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
// One octet per clock while o_in_ready is high; its result is registered in
// the output or skid register. The parser state register closes the loop.
// Synchronous reset returns the parser to expect a tag octet and loads the
// register reset masks. The skid stage absorbs one extra result, so the input
// stalls only after two results wait downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module openpgp_packet_deframer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire opd_pkg::t_in                        i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output opd_pkg::t_out                            o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [opd_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [opd_pkg::MASK_BITS-1:0]       i_cfg_wdata
);

    opd_pkg::t_state                 r_state;
    opd_pkg::t_state                 n_state;
    opd_pkg::t_out                   step_out;
    logic [opd_pkg::MASK_BITS-1:0]   r_valid_tag_mask;
    logic [opd_pkg::MASK_BITS-1:0]   r_partial_ok_mask;
    logic                            space;
    logic                            accept;

    assign o_in_ready = space;
    assign accept = i_in_valid && space;

    opd_step u_step (
        .i_state           (r_state),
        .i_in              (i_in_data),
        .i_valid_tag_mask  (r_valid_tag_mask),
        .i_partial_ok_mask (r_partial_ok_mask),
        .o_state           (n_state),
        .o_out             (step_out)
    );

    opd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_out),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: opd_pkg::PH_TAG, default: '0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_tag_mask <= opd_pkg::VALID_TAG_RESET;
            r_partial_ok_mask <= opd_pkg::PARTIAL_OK_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == opd_pkg::CFG_VALID_TAG) begin
                r_valid_tag_mask <= i_cfg_wdata;
            end
            if (i_cfg_idx == opd_pkg::CFG_PARTIAL_OK) begin
                r_partial_ok_mask <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire
